/* sv/fmfc_pkg.sv */
// ----------------------------------------------------------------------------
// fmfc_pkg
// shared widths, constants and register indexes of the frame motion field
// counter
// ----------------------------------------------------------------------------
package fmfc_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIFF_W = 9;
  localparam int unsigned MOT_W  = 8;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned THR_W  = 10;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned CNT_W  = 23;
  localparam int unsigned POS_W  = 14;
  localparam int unsigned IDX_W  = 2;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam int unsigned MAX_LINE_WIDTH_DEF   = 4096;
  localparam int unsigned MAX_FRAME_HEIGHT_DEF = 4096;

  localparam logic [POS_W-1:0] EDGE_MARGIN = POS_W'(16);

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(720);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [THR_W-1:0] STRONG_RST = THR_W'(36);
  localparam logic [THR_W-1:0] WEAK_RST   = THR_W'(18);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_STRONG_THR   = IDX_W'(2);
  localparam logic [IDX_W-1:0] CFG_WEAK_THR     = IDX_W'(3);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [MOT_W-1:0]         mot_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

/* sv/fmfc_motion.sv */
// ----------------------------------------------------------------------------
// fmfc_motion
// motion value of the center pixel: |b| - |a + d - 2b|, clamped to 0..255
// ----------------------------------------------------------------------------
module fmfc_motion (
  input  fmfc_pkg::diff_t diff_a_i,
  input  fmfc_pkg::diff_t diff_b_i,
  input  fmfc_pkg::diff_t diff_d_i,
  output fmfc_pkg::mot_t  motion_o
);
  import fmfc_pkg::*;

  localparam int unsigned EXT_W = DIFF_W + 2;

  logic signed [EXT_W-1:0] a_x, b_x, d_x;
  logic signed [EXT_W-1:0] sec_diff, abs_sec, abs_b, m_raw;

  always_comb begin
    a_x      = EXT_W'(diff_a_i);
    b_x      = EXT_W'(diff_b_i);
    d_x      = EXT_W'(diff_d_i);
    sec_diff = a_x + d_x - (b_x <<< 1);
    abs_sec  = sec_diff[EXT_W-1] ? -sec_diff : sec_diff;
    abs_b    = b_x[EXT_W-1] ? -b_x : b_x;
    m_raw    = abs_b - abs_sec;
    motion_o = m_raw[EXT_W-1] ? '0 : m_raw[MOT_W-1:0];
  end

endmodule

/* sv/frame_motion_field_counter_core.sv */
// ----------------------------------------------------------------------------
// frame_motion_field_counter_core
// counts strong and weak motion hits on even and odd rows of each frame
// a beat taken into the input register is processed when it advances; the frame
//   result is registered as the frame's last beat advances
// throughput: one pixel pair per cycle, set by the single input register and
//   the window update; stalls only while a frame's last beat meets
//   a waiting result
// reset: positions, windows and counts clear, registers take default thresholds and sizes
// ----------------------------------------------------------------------------
module frame_motion_field_counter_core #(
  parameter int unsigned MAX_LINE_WIDTH   = fmfc_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned MAX_FRAME_HEIGHT = fmfc_pkg::MAX_FRAME_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmfc_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [fmfc_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // cur_pixel, prev_pixel
  input  logic [fmfc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // even_strong_count, odd_strong_count, even_weak_count, odd_weak_count
  output logic [fmfc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import fmfc_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_FRAME_HEIGHT);
  localparam logic [POS_W-1:0] MAX_W = POS_W'(MAX_LINE_WIDTH);
  localparam logic [POS_W-1:0] MAX_H = POS_W'(MAX_FRAME_HEIGHT);
  localparam int unsigned PAD_W = OUT_TDATA_W - 4 * CNT_W;

  logic [DIM_W-1:0] width_q, height_q;
  logic [THR_W-1:0] strong_q, weak_q;

  logic             in_vld_q;
  logic [PIX_W-1:0] cur_q, prev_q;
  logic             in_acc, advance;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  diff_t            diff0_q, diff1_q, diff_cur;
  mot_t             mot0_q, mot1_q, mot_cur;
  cnt_t             es_q, os_q, ew_q, ow_q;
  cnt_t             es_d, os_d, ew_d, ow_d;

  logic             out_vld_q;
  cnt_t             o_es_q, o_os_q, o_ew_q, o_ow_q;

  logic [POS_W-1:0] w_eff, h_eff, col_x, row_x;
  logic [SUM_W-1:0] sum;
  logic             row_ok, col_ok, col_end, row_end, frame_end, odd;
  logic             hit_s, hit_w, out_load;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      strong_q <= STRONG_RST;
      weak_q   <= WEAK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_STRONG_THR:   strong_q <= cfg_data_i[THR_W-1:0];
        CFG_WEAK_THR:     weak_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance       = in_vld_q && (!frame_end || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q  <= s_axis_tdata[PIX_W-1:0];
      prev_q <= s_axis_tdata[2*PIX_W-1:PIX_W];
    end
  end

  // per-pixel datapath
  assign diff_cur = $signed({1'b0, cur_q}) - $signed({1'b0, prev_q});

  fmfc_motion u_motion (
    .diff_a_i (diff0_q),
    .diff_b_i (diff1_q),
    .diff_d_i (diff_cur),
    .motion_o (mot_cur)
  );

  always_comb begin
    w_eff = (POS_W'(width_q) > MAX_W) ? MAX_W : POS_W'(width_q);
    h_eff = (POS_W'(height_q) > MAX_H) ? MAX_H : POS_W'(height_q);
    col_x = POS_W'(col_q);
    row_x = POS_W'(row_q);
    sum   = SUM_W'(mot0_q) + SUM_W'(mot1_q) + SUM_W'(mot_cur);

    row_ok    = (row_x >= EDGE_MARGIN) && (row_x + EDGE_MARGIN + POS_W'(1) <= h_eff);
    col_ok    = (col_x >= EDGE_MARGIN + POS_W'(2)) &&
                (col_x + EDGE_MARGIN - POS_W'(1) <= w_eff);
    col_end   = (col_x + POS_W'(1)) >= w_eff;
    row_end   = (row_x + POS_W'(1)) >= h_eff;
    frame_end = col_end && row_end;
    odd       = row_q[0];

    hit_s = row_ok && col_ok && (sum > strong_q);
    hit_w = row_ok && col_ok && (sum > weak_q);

    es_d = (hit_s && !odd && es_q != CNT_MAX) ? es_q + cnt_t'(1) : es_q;
    os_d = (hit_s &&  odd && os_q != CNT_MAX) ? os_q + cnt_t'(1) : os_q;
    ew_d = (hit_w && !odd && ew_q != CNT_MAX) ? ew_q + cnt_t'(1) : ew_q;
    ow_d = (hit_w &&  odd && ow_q != CNT_MAX) ? ow_q + cnt_t'(1) : ow_q;

    col_d = col_end ? '0 : COL_W'(col_x + POS_W'(1));
    row_d = row_q;
    if (col_end) begin
      row_d = row_end ? '0 : ROW_W'(row_x + POS_W'(1));
    end
  end

  assign out_load = advance && frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      diff0_q <= '0;
      diff1_q <= '0;
      mot0_q  <= '0;
      mot1_q  <= '0;
      es_q    <= '0;
      os_q    <= '0;
      ew_q    <= '0;
      ow_q    <= '0;
    end else if (advance) begin
      col_q   <= col_d;
      row_q   <= row_d;
      diff0_q <= diff1_q;
      diff1_q <= diff_cur;
      mot0_q  <= mot1_q;
      mot1_q  <= mot_cur;
      if (frame_end) begin
        es_q <= '0;
        os_q <= '0;
        ew_q <= '0;
        ow_q <= '0;
      end else begin
        es_q <= es_d;
        os_q <= os_d;
        ew_q <= ew_d;
        ow_q <= ow_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_es_q <= es_d;
      o_os_q <= os_d;
      o_ew_q <= ew_d;
      o_ow_q <= ow_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, o_ow_q, o_ew_q, o_os_q, o_es_q};

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("pending result overwritten");

  a_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (es_q == '0 && os_q == '0 && ew_q == '0 && ow_q == '0))
    else $error("counters not cleared after frame end");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && col_end) |=> (col_q == '0))
    else $error("column not wrapped at row end");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q))
    else $error("input stalled without a waiting result");

endmodule

/* sim/frame_motion_field_counter_core_test.sv */
// ----------------------------------------------------------------------------
// frame_motion_field_counter_core_test
// Self-checking testbench for the frame motion field counter. A short script of
// pixel beats and register writes covers zero sizes, extreme differences and
// size changes in mid-frame. Random phases follow: small and loose frames,
// frame heights above the maximum, and frames whose counted window is reached by
// narrowing and cutting the frame through the registers. Each frame result is
// compared field by field with a cycle-free model of the counter. Both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module frame_motion_field_counter_core_test;
  import fmfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_GAP       = 4;
  localparam int RANDOM_PIXELS  = 950;
  localparam int RESULTS_WANTED = 48;

  localparam int EVEN_STRONG = 0;
  localparam int ODD_STRONG  = 1;
  localparam int EVEN_WEAK   = 2;
  localparam int ODD_WEAK    = 3;

  typedef logic [3:0][CNT_W-1:0] frame_tally_t;

  typedef enum logic {STEP_CFG, STEP_PIX} step_kind_e;
  typedef enum logic [1:0] {PAT_NOISE, PAT_SMOOTH, PAT_SOLID, PAT_FLIP} pattern_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [IDX_W-1:0] idx;
    logic [DIM_W-1:0] val;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] prev;
    logic             typed;
    frame_tally_t     want;
  } script_step_t;

  localparam frame_tally_t NO_HITS = '0;

  localparam script_step_t SCRIPT [21] = '{
    '{STEP_CFG, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_CFG, CFG_FRAME_HEIGHT, DIM_W'(0), 8'd0,   8'd0,   1'b0, NO_HITS},
    // zero sizes: every pixel closes a frame
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd0,   8'd0,   1'b1, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd255, 8'd0,   1'b1, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd0,   8'd255, 1'b1, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd255, 8'd255, 1'b1, NO_HITS},
    '{STEP_CFG, CFG_FRAME_WIDTH,  DIM_W'(1), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_CFG, CFG_FRAME_HEIGHT, DIM_W'(2), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd128, 8'd127, 1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd1,   8'd254, 1'b1, NO_HITS},
    '{STEP_CFG, CFG_FRAME_WIDTH,  DIM_W'(3), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd200, 8'd17,  1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd17,  8'd200, 1'b0, NO_HITS},
    // column already past the narrower row
    '{STEP_CFG, CFG_FRAME_WIDTH,  DIM_W'(1), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd99,  8'd100, 1'b0, NO_HITS},
    // row already past the lower frame
    '{STEP_CFG, CFG_FRAME_HEIGHT, DIM_W'(1), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd7,   8'd7,   1'b1, NO_HITS},
    '{STEP_CFG, CFG_FRAME_WIDTH,  DIM_W'(2), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_CFG, CFG_FRAME_HEIGHT, DIM_W'(1), 8'd0,   8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd255, 8'd0,   1'b0, NO_HITS},
    '{STEP_PIX, CFG_FRAME_WIDTH,  DIM_W'(0), 8'd0,   8'd255, 1'b1, NO_HITS}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [IDX_W-1:0]       cfg_idx_i;
  logic [DIM_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // model state
  logic [DIM_W-1:0] sz_width;
  logic [DIM_W-1:0] sz_height;
  logic [THR_W-1:0] thr_strong;
  logic [THR_W-1:0] thr_weak;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  diff_t            diff_hist [2];
  mot_t             mot_hist [2];
  frame_tally_t     tally;

  frame_tally_t tally_q [$];
  string        tally_name [4] = '{"even_strong_count", "odd_strong_count",
                                   "even_weak_count", "odd_weak_count"};
  int           fault_count = 0;
  int           pixels_fed = 0;
  int           frames_done = 0;
  bit           steady = 1'b0;

  frame_motion_field_counter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // cur_pixel, prev_pixel
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // even_strong, odd_strong, even_weak, odd_weak
  );

  always #10 clk_i = ~clk_i;

  function automatic void bump_tally(input int slot);
    if (tally[slot] != CNT_MAX) tally[slot] = tally[slot] + 1'b1;
  endfunction

  function automatic bit motion_step(input logic [PIX_W-1:0] cur,
                                     input logic [PIX_W-1:0] prev,
                                     output frame_tally_t done);
    int w, h, d, a, b, e, m, sum, c, r, margin;
    bit fired;
    fired  = 1'b0;
    margin = int'(EDGE_MARGIN);
    w = (sz_width > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : int'(sz_width);
    h = (sz_height > MAX_FRAME_HEIGHT_DEF) ? MAX_FRAME_HEIGHT_DEF : int'(sz_height);
    d = int'(cur) - int'(prev);
    a = int'(diff_hist[0]);
    b = int'(diff_hist[1]);
    e = a + d - 2 * b;
    m = (b < 0 ? -b : b) - (e < 0 ? -e : e);
    if (m < 0) m = 0;
    if (m > 255) m = 255;
    sum = int'(mot_hist[0]) + int'(mot_hist[1]) + m;
    c = int'(col_pos);
    r = int'(row_pos);
    if (r >= margin && r + margin + 1 <= h && c >= margin + 2 && c + margin - 1 <= w) begin
      if (sum > int'(thr_strong)) bump_tally(r[0] ? ODD_STRONG : EVEN_STRONG);
      if (sum > int'(thr_weak)) bump_tally(r[0] ? ODD_WEAK : EVEN_WEAK);
    end
    diff_hist[0] = diff_hist[1];
    diff_hist[1] = diff_t'(d);
    mot_hist[0]  = mot_hist[1];
    mot_hist[1]  = mot_t'(m);
    if (c + 1 >= w) begin
      col_pos = '0;
      if (r + 1 >= h) begin
        row_pos = '0;
        fired   = 1'b1;
        frames_done++;
      end else begin
        row_pos = POS_W'(r + 1);
      end
    end else begin
      col_pos = POS_W'(c + 1);
    end
    done = tally;
    if (fired) tally = '0;
    return fired;
  endfunction

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input int value);
    logic [DIM_W-1:0] v;
    v = DIM_W'(value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:  sz_width   = v;
      CFG_FRAME_HEIGHT: sz_height  = v;
      CFG_STRONG_THR:   thr_strong = v[THR_W-1:0];
      CFG_WEAK_THR:     thr_weak   = v[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic feed_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] prev,
                            input bit typed = 1'b0, input frame_tally_t want = '0);
    int gap;
    frame_tally_t done;
    bit fired;
    gap = steady ? 0 : $urandom_range(0, 4);
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prev, cur};
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_fed++;
    fired = motion_step(cur, prev, done);
    if (fired || typed) tally_q.push_back(typed ? want : done);
  endtask

  task automatic feed_pattern(input pattern_e mode, input int base);
    int p, c;
    case (mode)
      PAT_SMOOTH: begin
        p = $urandom_range(64, 191);
        c = p + base + int'($urandom_range(0, 6)) - 3;
      end
      PAT_SOLID: begin
        p = (base < 0) ? 255 : 0;
        c = 255 - p;
      end
      PAT_FLIP: begin
        p = $urandom_range(0, 1) ? 255 : 0;
        c = 255 - p;
      end
      default: begin
        p = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
      end
    endcase
    feed_pixel(PIX_W'(c), PIX_W'(p));
  endtask

  task automatic finish_frame(input pattern_e mode);
    int seen;
    seen = frames_done;
    while (frames_done == seen) feed_pattern(mode, 0);
  endtask

  function automatic int pick_threshold();
    int t;
    case ($urandom_range(0, 7))
      0: t = 0;
      1: t = 765;
      2: t = 1023;
      default: t = $urandom_range(0, 200);
    endcase
    if ($urandom_range(0, 3) == 0) t = t | (int'($urandom_range(0, 7)) << THR_W);
    return t;
  endfunction

  // close the running frame, walk to the first counted row on narrow rows, widen
  // for a few counted rows, then lower the height so the frame ends
  task automatic run_counted_frame(input bit new_thresholds);
    int span, rows;
    pattern_e mode;
    cfg_write(CFG_FRAME_WIDTH, 1);
    cfg_write(CFG_FRAME_HEIGHT, 0);
    finish_frame(PAT_NOISE);
    cfg_write(CFG_FRAME_WIDTH, $urandom_range(1, 2));
    cfg_write(CFG_FRAME_HEIGHT, ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                                           : $urandom_range(40, 4096));
    if (new_thresholds) begin
      cfg_write(CFG_STRONG_THR, pick_threshold());
      cfg_write(CFG_WEAK_THR, pick_threshold());
    end
    while (row_pos < EDGE_MARGIN) feed_pattern(PAT_NOISE, 0);
    span = $urandom_range(32, 48);
    rows = $urandom_range(2, 5);
    cfg_write(CFG_FRAME_WIDTH, span);
    for (int i = 0; i < rows; i++) begin
      mode = pattern_e'($urandom_range(0, 3));
      repeat (span) feed_pattern(mode, int'($urandom_range(0, 120)) - 60);
    end
    cfg_write(CFG_FRAME_HEIGHT, $urandom_range(0, 17));
    finish_frame(PAT_NOISE);
  endtask

  task automatic run_loose_phase();
    int span, rows, count, base;
    pattern_e mode;
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    rows = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    cfg_write(CFG_FRAME_WIDTH, span);
    cfg_write(CFG_FRAME_HEIGHT, rows);
    if ($urandom_range(0, 1)) cfg_write(CFG_STRONG_THR, pick_threshold());
    if ($urandom_range(0, 1)) cfg_write(CFG_WEAK_THR, pick_threshold());
    mode  = pattern_e'($urandom_range(0, 3));
    base  = int'($urandom_range(0, 120)) - 60;
    count = 2 * (span > 0 ? span : 1) * (rows > 0 ? rows : 1);
    count = $urandom_range(1, count > 80 ? 80 : count);
    repeat (count) feed_pattern(mode, base);
  endtask

  task automatic check_tally(input frame_tally_t got);
    frame_tally_t want;
    if (tally_q.size() == 0) begin
      $error("frame result with none expected: %h", got);
      fault_count++;
      return;
    end
    want = tally_q.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (got[i] !== want[i]) begin
        $error("%s: expected %0d, got %0d", tally_name[i], want[i], got[i]);
        fault_count++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (stall - 1) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_tally(frame_tally_t'(m_axis_tdata[4*CNT_W-1:0]));
    end
  end

  initial begin : stimulus
    int rand_start;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sz_width      = WIDTH_RST;
    sz_height     = HEIGHT_RST;
    thr_strong    = STRONG_RST;
    thr_weak      = WEAK_RST;
    col_pos       = '0;
    row_pos       = '0;
    diff_hist     = '{default: '0};
    mot_hist      = '{default: '0};
    tally         = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(SCRIPT); i++) begin
      if (SCRIPT[i].kind == STEP_CFG) cfg_write(SCRIPT[i].idx, SCRIPT[i].val);
      else feed_pixel(SCRIPT[i].cur, SCRIPT[i].prev, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // thresholds still at their reset values here
    run_counted_frame(1'b0);

    rand_start = pixels_fed;
    while (pixels_fed - rand_start < RANDOM_PIXELS || frames_done < RESULTS_WANTED) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) run_counted_frame(1'b1);
      else run_loose_phase();
    end

    steady = 1'b0;
    wait_idle();
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
